### design/hrsd_pkg.sv
// Shared types and constants of the HTTP response status and date parser.
`timescale 1ns / 1ps
`default_nettype none

package hrsd_pkg;

    localparam int TAG_LEN   = 6;
    localparam int TAG_IDX_W = 3;

    // The tag that opens the date header, matched byte by byte.
    localparam logic [7:0] DATE_TAG [TAG_LEN] = '{8'h44, 8'h61, 8'h74, 8'h65, 8'h3A, 8'h20};

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int ZONE_W = 18;
    localparam logic signed [ZONE_W-1:0] ZONE_RESET = 18'sd32400;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_ZONE = 1'b0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // One received byte after classification by the front end.
    typedef struct packed {
        logic               last;
        logic               is_digit;
        logic [3:0]         digit;
        logic               is_colon;
        logic [TAG_LEN-1:0] tag_eq;
    } item_t;

    // Raw result of one response, before the time is folded into seconds.
    typedef struct packed {
        logic       status_ok;
        logic [9:0] status_code;
        logic       time_ok;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
    } record_t;

endpackage

`default_nettype wire

### design/hrsd_front.sv
// Front end: accepts received bytes and classifies each one.
`timescale 1ns / 1ps
`default_nettype none

module hrsd_front (
    input  wire logic          [7:0] rx_byte,
    input  wire logic                last_byte,
    input  wire logic                push,
    input  wire logic                full,
    output hrsd_pkg::item_t          item,
    output logic                     item_write
);
    import hrsd_pkg::*;

    always_comb
    begin
        item.last     = last_byte;
        item.is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
        item.digit    = rx_byte[3:0];
        item.is_colon = (rx_byte == CHAR_COLON);
        for (int k = 0; k < TAG_LEN; k++)
        begin
            item.tag_eq[k] = (rx_byte == DATE_TAG[k]);
        end
    end

    assign item_write = push && !full;

endmodule

`default_nettype wire

### design/hrsd_queue.sv
// Short queue of classified items between the front end and the parser.
`timescale 1ns / 1ps
`default_nettype none

module hrsd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  hrsd_pkg::item_t      wr_item,
    output logic                 full,
    input  wire logic            rd_en,
    output hrsd_pkg::item_t      rd_item,
    output logic                 rd_valid
);
    import hrsd_pkg::*;

    item_t                  mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    assign full     = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/hrsd_back.sv
// Parser: walks the classified bytes and builds one record per response.
`timescale 1ns / 1ps
`default_nettype none

module hrsd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  hrsd_pkg::item_t      head,
    input  wire logic            head_valid,
    output logic                 consume,
    input  wire logic            rec_ready,
    output logic                 rec_valid,
    output hrsd_pkg::record_t    rec
);
    import hrsd_pkg::*;

    typedef enum logic [2:0] {
        PH_COLON,
        PH_MIN_HI,
        PH_MIN_LO,
        PH_SEP,
        PH_SEC_HI,
        PH_SEC_LO,
        PH_DONE
    } phase_t;

    localparam logic [3:0] POS_SAT = 4'd12;
    localparam logic [3:0] POS_ST0 = 4'd9;
    localparam logic [3:0] POS_ST2 = 4'd11;

    logic [3:0]           pos_reg,      pos_next;
    logic [9:0]           status_reg,   status_next;
    logic                 sbad_reg,     sbad_next;
    logic [TAG_IDX_W-1:0] tidx_reg,     tidx_next;
    logic                 seen_reg,     seen_next;
    logic                 hi_ok_reg,    hi_ok_next;
    logic [3:0]           hi_val_reg,   hi_val_next;
    logic                 lo_ok_reg,    lo_ok_next;
    logic [3:0]           lo_val_reg,   lo_val_next;
    phase_t               phase_reg,    phase_next;
    logic [6:0]           hours_reg,    hours_next;
    logic [6:0]           minutes_reg,  minutes_next;
    logic [6:0]           seconds_reg,  seconds_next;
    logic                 tbad_reg,     tbad_next;
    logic [13:0]          status_mac;
    logic [6:0]           hours_hi;

    function automatic logic [6:0] mac7(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] full_sum;
        full_sum = {4'b0, acc} * 11'd10 + {7'b0, d};
        return full_sum[6:0];
    endfunction

    // A last item only moves on when the result stage has room for its record.
    assign consume   = head_valid && (!head.last || rec_ready);
    assign rec_valid = consume && head.last;

    always_comb
    begin
        pos_next     = pos_reg;
        status_next  = status_reg;
        sbad_next    = sbad_reg;
        tidx_next    = tidx_reg;
        seen_next    = seen_reg;
        phase_next   = phase_reg;
        hours_next   = hours_reg;
        minutes_next = minutes_reg;
        seconds_next = seconds_reg;
        tbad_next    = tbad_reg;
        status_mac   = {4'b0, status_reg} * 14'd10 + {10'b0, head.digit};
        hours_hi     = hi_ok_reg ? {3'b0, hi_val_reg} : 7'd0;

        if ((pos_reg >= POS_ST0) && (pos_reg <= POS_ST2))
        begin
            if (head.is_digit)
            begin
                status_next = status_mac[9:0];
            end
            else
            begin
                sbad_next = 1'b1;
            end
        end

        if (seen_reg)
        begin
            unique case (phase_reg)
                PH_COLON:
                begin
                    if (head.is_colon)
                    begin
                        hours_next = lo_ok_reg ? mac7(hours_hi, lo_val_reg) : hours_hi;
                        tbad_next  = tbad_reg || !hi_ok_reg || !lo_ok_reg;
                        phase_next = PH_MIN_HI;
                    end
                end
                PH_MIN_HI, PH_MIN_LO:
                begin
                    if (head.is_digit)
                    begin
                        minutes_next = mac7(minutes_reg, head.digit);
                    end
                    else
                    begin
                        tbad_next = 1'b1;
                    end
                    phase_next = (phase_reg == PH_MIN_HI) ? PH_MIN_LO : PH_SEP;
                end
                PH_SEP:
                begin
                    phase_next = PH_SEC_HI;
                end
                PH_SEC_HI, PH_SEC_LO:
                begin
                    if (head.is_digit)
                    begin
                        seconds_next = mac7(seconds_reg, head.digit);
                    end
                    else
                    begin
                        tbad_next = 1'b1;
                    end
                    phase_next = (phase_reg == PH_SEC_HI) ? PH_SEC_LO : PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else
        begin
            // The tag has no self-overlap, so a mismatch restarts at its first byte.
            if (head.tag_eq[tidx_reg])
            begin
                if (tidx_reg == TAG_IDX_W'(TAG_LEN - 1))
                begin
                    seen_next = 1'b1;
                    tidx_next = '0;
                end
                else
                begin
                    tidx_next = tidx_reg + 1'b1;
                end
            end
            else
            begin
                tidx_next = head.tag_eq[0] ? TAG_IDX_W'(1) : '0;
            end
        end

        hi_ok_next  = lo_ok_reg;
        hi_val_next = lo_val_reg;
        lo_ok_next  = head.is_digit;
        lo_val_next = head.digit;
        if (pos_reg < POS_SAT)
        begin
            pos_next = pos_reg + 1'b1;
        end

        rec.status_ok   = (pos_next >= POS_SAT) && !sbad_next;
        rec.status_code = rec.status_ok ? status_next : 10'd0;
        rec.time_ok     = seen_next && (phase_next == PH_DONE) && !tbad_next;
        rec.hours       = hours_next;
        rec.minutes     = minutes_next;
        rec.seconds     = seconds_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            status_reg  <= '0;
            sbad_reg    <= 1'b0;
            tidx_reg    <= '0;
            seen_reg    <= 1'b0;
            hi_ok_reg   <= 1'b0;
            hi_val_reg  <= '0;
            lo_ok_reg   <= 1'b0;
            lo_val_reg  <= '0;
            phase_reg   <= PH_COLON;
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
            tbad_reg    <= 1'b0;
        end
        else if (consume && head.last)
        begin
            // The response is finished: start the next one from a clean state.
            pos_reg     <= '0;
            status_reg  <= '0;
            sbad_reg    <= 1'b0;
            tidx_reg    <= '0;
            seen_reg    <= 1'b0;
            hi_ok_reg   <= 1'b0;
            hi_val_reg  <= '0;
            lo_ok_reg   <= 1'b0;
            lo_val_reg  <= '0;
            phase_reg   <= PH_COLON;
            hours_reg   <= '0;
            minutes_reg <= '0;
            seconds_reg <= '0;
            tbad_reg    <= 1'b0;
        end
        else if (consume)
        begin
            pos_reg     <= pos_next;
            status_reg  <= status_next;
            sbad_reg    <= sbad_next;
            tidx_reg    <= tidx_next;
            seen_reg    <= seen_next;
            hi_ok_reg   <= hi_ok_next;
            hi_val_reg  <= hi_val_next;
            lo_ok_reg   <= lo_ok_next;
            lo_val_reg  <= lo_val_next;
            phase_reg   <= phase_next;
            hours_reg   <= hours_next;
            minutes_reg <= minutes_next;
            seconds_reg <= seconds_next;
            tbad_reg    <= tbad_next;
        end
    end

endmodule

`default_nettype wire

### design/hrsd_result.sv
// Result stage: folds the time into seconds and holds results until popped.
`timescale 1ns / 1ps
`default_nettype none

module hrsd_result (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                rec_valid,
    input  hrsd_pkg::record_t                        rec,
    output logic                                     rec_ready,
    input  wire logic signed [hrsd_pkg::ZONE_W-1:0]  zone_offset,
    input  wire logic                                pop,
    output logic                                     empty,
    output logic                                     status_ok,
    output logic                            [9:0]    status_code,
    output logic                                     time_ok,
    output logic signed                     [19:0]   local_seconds
);
    import hrsd_pkg::*;

    logic       a_valid_reg;
    record_t    a_rec_reg;
    logic       b_valid_reg;
    logic       b_status_ok_reg;
    logic [9:0] b_status_code_reg;
    logic       b_time_ok_reg;
    logic [19:0] b_seconds_reg;
    logic       b_ready;
    logic       a_move;
    logic [19:0] total;

    assign b_ready   = !b_valid_reg || pop;
    assign a_move    = a_valid_reg && b_ready;
    assign rec_ready = !a_valid_reg || b_ready;

    always_comb
    begin
        total = {13'b0, a_rec_reg.hours} * 20'd3600
              + {13'b0, a_rec_reg.minutes} * 20'd60
              + {13'b0, a_rec_reg.seconds}
              + {{(20 - ZONE_W){zone_offset[ZONE_W-1]}}, zone_offset};
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid && rec_ready)
        begin
            a_rec_reg <= rec;
        end
        if (a_move)
        begin
            b_status_ok_reg   <= a_rec_reg.status_ok;
            b_status_code_reg <= a_rec_reg.status_code;
            b_time_ok_reg     <= a_rec_reg.time_ok;
            b_seconds_reg     <= a_rec_reg.time_ok ? total : 20'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (rec_ready)
            begin
                a_valid_reg <= rec_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    assign empty         = !b_valid_reg;
    assign status_ok     = b_status_ok_reg;
    assign status_code   = b_status_code_reg;
    assign time_ok       = b_time_ok_reg;
    assign local_seconds = b_seconds_reg;

endmodule

`default_nettype wire

### design/http_response_status_date_parser.sv
// Top level of the HTTP response status and date parser.
// Bytes of one response enter one item per clock while full is low; the last byte carries
// last_byte. Each byte is classified on entry and written to a four-entry queue, and the
// parser takes one byte from it per cycle while it holds one, so the sustained rate is one
// byte per cycle, set by the parser's per-byte state update. Only the last byte of a
// response waits for room in the result stage. The result of a response is registered
// first in a stage that converts the time to seconds and adds the zone offset, and then
// in an output register that holds it until popped. The zone offset register sits at
// address 0 and should be written while no response is in flight.
`timescale 1ns / 1ps
`default_nettype none

module http_response_status_date_parser (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hrsd_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [hrsd_pkg::DATA_W-1:0]     pwdata,
    output logic      [hrsd_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            last_byte,
    input  wire logic                            push,
    output logic                                 full,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 status_ok,
    output logic      [9:0]                      status_code,
    output logic                                 time_ok,
    output logic signed [19:0]                   local_seconds
);
    import hrsd_pkg::*;

    logic signed [ZONE_W-1:0] zone_reg;
    logic                     zone_write;
    item_t                    front_item;
    logic                     front_write;
    item_t                    head;
    logic                     head_valid;
    logic                     consume;
    logic                     rec_valid;
    logic                     rec_ready;
    record_t                  rec;

    assign pready     = 1'b1;
    assign zone_write = psel && penable && pwrite && pready && (paddr[2] == REG_ZONE);
    assign prdata     = (paddr[2] == REG_ZONE) ?
                        {{(DATA_W - ZONE_W){zone_reg[ZONE_W-1]}}, zone_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= ZONE_RESET;
        end
        else if (zone_write)
        begin
            zone_reg <= pwdata[ZONE_W-1:0];
        end
    end

    hrsd_front u_front (
        .rx_byte    (rx_byte),
        .last_byte  (last_byte),
        .push       (push),
        .full       (full),
        .item       (front_item),
        .item_write (front_write)
    );

    hrsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_write),
        .wr_item  (front_item),
        .full     (full),
        .rd_en    (consume),
        .rd_item  (head),
        .rd_valid (head_valid)
    );

    hrsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .consume    (consume),
        .rec_ready  (rec_ready),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    hrsd_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_valid     (rec_valid),
        .rec           (rec),
        .rec_ready     (rec_ready),
        .zone_offset   (zone_reg),
        .pop           (pop),
        .empty         (empty),
        .status_ok     (status_ok),
        .status_code   (status_code),
        .time_ok       (time_ok),
        .local_seconds (local_seconds)
    );

endmodule

`default_nettype wire

### design/hrsd_checker.sv
// Port-level checks of the parser, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module hrsd_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic               status_ok,
    input wire logic [9:0]         status_code,
    input wire logic               time_ok,
    input wire logic signed [19:0] local_seconds
);

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status_code) && $stable(local_seconds)
                           && $stable(status_ok) && $stable(time_ok))
    else $error("waiting result changed before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !status_ok |-> status_code == 10'd0)
    else $error("status code set without a valid status");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status_ok |-> status_code <= 10'd999)
    else $error("status code above three digits");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !time_ok |-> local_seconds == 20'sd0)
    else $error("time value set without a valid time");

endmodule

bind http_response_status_date_parser hrsd_checker u_hrsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .status_ok     (status_ok),
    .status_code   (status_code),
    .time_ok       (time_ok),
    .local_seconds (local_seconds)
);

`default_nettype wire
